@@ sv/obd2_pkg.sv @@
// Shared constants and encode helpers for the OBD-II mode 01 responder
package obd2_pkg;

  // Accepted request identifiers and fixed response bytes
  localparam logic [10:0] REQ_ID_PHYS = 11'h7E0;
  localparam logic [10:0] REQ_ID_FUNC = 11'h7DF;
  localparam logic [7:0]  SVC_MODE01  = 8'h01;
  localparam logic [7:0]  POS_RESP    = 8'h41;
  localparam logic [7:0]  PAD_BYTE    = 8'h55;
  localparam logic [7:0]  PCI_HI_MASK = 8'hF0;
  localparam logic [7:0]  PCI_MIN_LEN = 8'h02;
  localparam logic [7:0]  LEN_BASE    = 8'h02;

  // Supported PIDs
  localparam logic [7:0] PID_SUPP_00  = 8'h00;
  localparam logic [7:0] PID_COOLANT  = 8'h05;
  localparam logic [7:0] PID_MAP      = 8'h0B;
  localparam logic [7:0] PID_RPM      = 8'h0C;
  localparam logic [7:0] PID_SPEED    = 8'h0D;
  localparam logic [7:0] PID_IAT      = 8'h0F;
  localparam logic [7:0] PID_SUPP_20  = 8'h20;
  localparam logic [7:0] PID_FUEL     = 8'h2F;
  localparam logic [7:0] PID_SUPP_40  = 8'h40;
  localparam logic [7:0] PID_VOLTAGE  = 8'h42;
  localparam logic [7:0] PID_ETHANOL  = 8'h52;

  localparam int unsigned NUM_PIDS = 10;
  localparam logic [7:0] SUPPORTED_PIDS [NUM_PIDS] = '{
    PID_COOLANT, PID_MAP, PID_RPM, PID_SPEED, PID_IAT,
    PID_SUPP_20, PID_FUEL, PID_SUPP_40, PID_VOLTAGE, PID_ETHANOL
  };

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ECM_SILENT = 2'd0,
    CFG_BUS_SILENT = 2'd1,
    CFG_IAT        = 2'd2,
    CFG_ETHANOL    = 2'd3
  } cfg_idx_e;

  localparam logic signed [8:0] IAT_RESET     = 9'sd32;
  localparam logic [6:0]        ETHANOL_RESET = 7'd27;

  // J1979 support bitmap: bit (32 - (p - base)) set for each supported p
  // in (base, base + 32]. Evaluated at elaboration only.
  function automatic logic [31:0] support_map(input logic [7:0] base);
    logic [31:0] m;
    logic [8:0]  off;
    m = '0;
    for (int i = 0; i < NUM_PIDS; i++) begin
      off = {1'b0, SUPPORTED_PIDS[i]} - {1'b0, base};
      if ((SUPPORTED_PIDS[i] > base) && (off <= 9'd32)) begin
        m[5'(9'd32 - off)] = 1'b1;
      end
    end
    return m;
  endfunction

  localparam logic [31:0] SUPP_MAP_00 = support_map(PID_SUPP_00);
  localparam logic [31:0] SUPP_MAP_20 = support_map(PID_SUPP_20);
  localparam logic [31:0] SUPP_MAP_40 = support_map(PID_SUPP_40);

  // Temperature + 40, saturated to 0..255
  function automatic logic [7:0] temp_code(input logic signed [8:0] t);
    logic signed [9:0] v;
    v = 10'(t) + 10'sd40;
    if (v[9]) begin
      return 8'd0;
    end else if (v[8]) begin
      return 8'hFF;
    end
    return v[7:0];
  endfunction

  // floor(p * 255 / 100), saturated to 255; /100 by reciprocal 2^22 / 100
  localparam logic [15:0] PCT_RECIP = 16'd41944;
  localparam int unsigned PCT_SHIFT = 22;

  function automatic logic [7:0] pct_code(input logic [6:0] p);
    logic [14:0] v;
    logic [30:0] prod;
    logic [8:0]  q;
    v    = {p, 8'd0} - 15'(p);
    prod = 31'(v) * 31'(PCT_RECIP);
    q    = prod[PCT_SHIFT +: 9];
    if (q > 9'd255) begin
      return 8'hFF;
    end
    return q[7:0];
  endfunction

endpackage

@@ sv/obd2_mode01_responder.sv @@
// Channel  | Handshake                  | Payload
// ---------+----------------------------+---------------------------------------------
// request  | in_valid_i / in_stall_o    | frame_id_i .. fuel_pct_i (CAN frame + values)
// response | out_valid_o / out_stall_i  | resp_byte0_o .. resp_byte7_o
// config   | cfg_we_i                   | cfg_idx_i, cfg_wdata_i
//
// A request lands in the input register, is decoded and encoded in one pass, and
// the response sits in the output register.
// One request is taken every cycle while in_stall_o is low; rejected or unsupported
// requests are dropped at the input register and never wait for the output side.
// in_stall_o rises only when the input register holds a request that answers
// while the output register is full and stalled.
// Reset (rst_ni low, asynchronous) empties both registers and restores the
// configuration defaults.
module obd2_mode01_responder
  import obd2_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,

  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [10:0]       frame_id_i,
  input  logic [7:0]        pci_byte_i,
  input  logic [7:0]        service_mode_i,
  input  logic [7:0]        pid_i,
  input  logic [13:0]       engine_rpm_i,
  input  logic [7:0]        speed_kmh_i,
  input  logic [7:0]        manifold_kpa_i,
  input  logic signed [8:0] coolant_c_i,
  input  logic [15:0]       supply_mv_i,
  input  logic [6:0]        fuel_pct_i,

  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        resp_byte0_o,
  output logic [7:0]        resp_byte1_o,
  output logic [7:0]        resp_byte2_o,
  output logic [7:0]        resp_byte3_o,
  output logic [7:0]        resp_byte4_o,
  output logic [7:0]        resp_byte5_o,
  output logic [7:0]        resp_byte6_o,
  output logic [7:0]        resp_byte7_o,

  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [8:0]        cfg_wdata_i
);

  // Configuration registers
  logic              ecm_silent_q;
  logic              bus_silent_q;
  logic signed [8:0] iat_q;
  logic [6:0]        ethanol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ecm_silent_q <= 1'b0;
      bus_silent_q <= 1'b0;
      iat_q        <= IAT_RESET;
      ethanol_q    <= ETHANOL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ECM_SILENT: ecm_silent_q <= cfg_wdata_i[0];
        CFG_BUS_SILENT: bus_silent_q <= cfg_wdata_i[0];
        CFG_IAT:        iat_q        <= cfg_wdata_i;
        CFG_ETHANOL:    ethanol_q    <= cfg_wdata_i[6:0];
        default:        ;
      endcase
    end
  end

  // Input register
  logic              s1_valid_q;
  logic              s1_valid_d;
  logic [10:0]       s1_id_q;
  logic [7:0]        s1_pci_q;
  logic [7:0]        s1_mode_q;
  logic [7:0]        s1_pid_q;
  logic [13:0]       s1_rpm_q;
  logic [7:0]        s1_spd_q;
  logic [7:0]        s1_kpa_q;
  logic signed [8:0] s1_cool_q;
  logic [15:0]       s1_mv_q;
  logic [6:0]        s1_fuel_q;

  logic in_accept;
  logic s1_go;
  logic out_free;
  logic resp_hit;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_o || !out_stall_i;
  // a request with no response leaves at once; one with a response needs room
  assign s1_go      = s1_valid_q && (!resp_hit || out_free);
  assign in_stall_o = s1_valid_q && !s1_go;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_id_q   <= frame_id_i;
      s1_pci_q  <= pci_byte_i;
      s1_mode_q <= service_mode_i;
      s1_pid_q  <= pid_i;
      s1_rpm_q  <= engine_rpm_i;
      s1_spd_q  <= speed_kmh_i;
      s1_kpa_q  <= manifold_kpa_i;
      s1_cool_q <= coolant_c_i;
      s1_mv_q   <= supply_mv_i;
      s1_fuel_q <= fuel_pct_i;
    end
  end

  // Request check
  logic req_ok;
  assign req_ok = ((s1_id_q == REQ_ID_PHYS) || (s1_id_q == REQ_ID_FUNC))
               && ((s1_pci_q & PCI_HI_MASK) == 8'h00)
               && (s1_pci_q >= PCI_MIN_LEN)
               && (s1_mode_q == SVC_MODE01)
               && !ecm_silent_q && !bus_silent_q;

  // PID encode
  logic              pid_ok;
  logic [2:0]        n_data;
  logic [3:0][7:0]   data;
  logic [15:0]       rpm_raw;

  assign rpm_raw = {s1_rpm_q, 2'b00};

  always_comb begin
    pid_ok = 1'b1;
    n_data = 3'd1;
    data   = {4{PAD_BYTE}};
    case (s1_pid_q)
      PID_SUPP_00: begin
        data   = SUPP_MAP_00;
        n_data = 3'd4;
      end
      PID_SUPP_20: begin
        data   = SUPP_MAP_20;
        n_data = 3'd4;
      end
      PID_SUPP_40: begin
        data   = SUPP_MAP_40;
        n_data = 3'd4;
      end
      PID_COOLANT: data[3] = temp_code(s1_cool_q);
      PID_MAP:     data[3] = s1_kpa_q;
      PID_RPM: begin
        data[3] = rpm_raw[15:8];
        data[2] = rpm_raw[7:0];
        n_data  = 3'd2;
      end
      PID_SPEED:   data[3] = s1_spd_q;
      PID_IAT:     data[3] = temp_code(iat_q);
      PID_FUEL:    data[3] = pct_code(s1_fuel_q);
      PID_VOLTAGE: begin
        data[3] = s1_mv_q[15:8];
        data[2] = s1_mv_q[7:0];
        n_data  = 3'd2;
      end
      PID_ETHANOL: data[3] = pct_code(ethanol_q);
      default:     pid_ok  = 1'b0;
    endcase
  end

  assign resp_hit = req_ok && pid_ok;

  // Output register
  logic            out_valid_q;
  logic            out_valid_d;
  logic            out_load;
  logic [7:0][7:0] rsp_q;
  logic [7:0][7:0] rsp_d;

  assign out_load = s1_go && resp_hit;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = out_load;
    end
  end

  assign rsp_d = {PAD_BYTE, data[0], data[1], data[2], data[3], s1_pid_q, POS_RESP,
                  LEN_BASE + 8'(n_data)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign resp_byte0_o = rsp_q[0];
  assign resp_byte1_o = rsp_q[1];
  assign resp_byte2_o = rsp_q[2];
  assign resp_byte3_o = rsp_q[3];
  assign resp_byte4_o = rsp_q[4];
  assign resp_byte5_o = rsp_q[5];
  assign resp_byte6_o = rsp_q[6];
  assign resp_byte7_o = rsp_q[7];

  // Checks

  // a fresh response always comes from a request held in the input register
  a_rsp_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("response appeared without a held request");

  // an empty input register never holds off the requester
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("stall raised with empty input register");

  // a taken response with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !out_load) |=> !out_valid_q)
    else $error("output register did not drain");

  // a held response has a legal length and fixed framing bytes
  a_framing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((rsp_q[1] == POS_RESP) && (rsp_q[7] == PAD_BYTE)
                     && ((rsp_q[0] == 8'd3) || (rsp_q[0] == 8'd4)
                         || (rsp_q[0] == 8'd6))))
    else $error("malformed response frame");

endmodule
